@@ sv/evr_pkg.sv @@
// Package for the eased volume ramp: widths, codes, curve decode.
// Used by evr_div, evr_mul, eased_volume_ramp and the bench; no dependencies.
package evr_pkg;

  localparam int FrameBits = 24;
  localparam int GainFrac  = 16;
  localparam int GainBits  = GainFrac + 1;
  localparam int DivBits   = FrameBits + GainFrac;
  localparam int DivCntW   = $clog2(DivBits + 1);
  localparam int SampBits  = 32;
  localparam int ProdBits  = SampBits + GainBits;
  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 24;

  localparam logic [GainBits-1:0] GainOne  = GainBits'(1) << GainFrac;
  localparam logic [GainBits-1:0] GainHalf = GainBits'(1) << (GainFrac - 1);

  typedef enum logic [CfgAddrW-1:0] {
    REG_CURVE  = 3'd0,
    REG_START  = 3'd1,
    REG_TARGET = 3'd2,
    REG_FRAMES = 3'd3,
    REG_WIDE   = 3'd4,
    REG_CHAN   = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_BYPASS = 2'd0,
    DIR_RISE   = 2'd1,
    DIR_FALL   = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    FORM_IN    = 2'd0,
    FORM_OUT   = 2'd1,
    FORM_INOUT = 2'd2
  } form_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_POW, S_POWW, S_BLD, S_BLDW,
    S_SCL, S_SCLW, S_SCR, S_SCRW, S_OUT
  } state_t;

  typedef struct packed {
    logic       linear;
    logic [2:0] power;
    form_t      form;
  } curve_t;

  function automatic curve_t curve_decode(input logic [3:0] sel);
    curve_t c;
    c.linear = 1'b0;
    c.power  = 3'd2;
    c.form   = FORM_IN;
    case (sel)
      4'd1:  begin c.power = 3'd2; c.form = FORM_IN;    end
      4'd2:  begin c.power = 3'd2; c.form = FORM_OUT;   end
      4'd3:  begin c.power = 3'd2; c.form = FORM_INOUT; end
      4'd4:  begin c.power = 3'd3; c.form = FORM_IN;    end
      4'd5:  begin c.power = 3'd3; c.form = FORM_OUT;   end
      4'd6:  begin c.power = 3'd3; c.form = FORM_INOUT; end
      4'd7:  begin c.power = 3'd4; c.form = FORM_IN;    end
      4'd8:  begin c.power = 3'd4; c.form = FORM_OUT;   end
      4'd9:  begin c.power = 3'd4; c.form = FORM_INOUT; end
      4'd10: begin c.power = 3'd5; c.form = FORM_IN;    end
      4'd11: begin c.power = 3'd5; c.form = FORM_OUT;   end
      4'd12: begin c.power = 3'd5; c.form = FORM_INOUT; end
      default: c.linear = 1'b1;
    endcase
    return c;
  endfunction

endpackage

@@ sv/eased_volume_ramp.sv @@
// Eased volume ramp: one stereo frame in, gain-scaled frame out. Bypass frames,
// zero- and one-frame ramps and frames after the ramp's end skip the divider; a
// ramp frame runs the 40-step serial divider for the ramp position, then the single
// shared multiplier, which runs the curve powers, the blend and both channels in
// turn. in_tready is high only while the sequencer is idle; one finished frame can
// wait in the output register while the next is accepted.
// Depends on evr_pkg, evr_div, evr_mul.
module eased_volume_ramp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,   // sample_left, sample_right
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [87:0]                   out_tdata,  // scaled_left, scaled_right, gain_used
  input  logic                          cfg_we,
  input  logic [evr_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [evr_pkg::CfgDataW-1:0]  cfg_wdata
);

  localparam int GB = evr_pkg::GainBits;
  localparam int FB = evr_pkg::FrameBits;
  localparam int SB = evr_pkg::SampBits;
  localparam int GF = evr_pkg::GainFrac;

  evr_pkg::state_t state_r, state_nxt;

  logic [3:0]    curve_r, curve_nxt;
  logic [GB-1:0] start_r, start_nxt, target_r, target_nxt;
  logic [FB-1:0] frames_r, frames_nxt;
  logic          wide_r, wide_nxt;
  logic [1:0]    chan_r, chan_nxt;

  logic [FB-1:0]     fd_r, fd_nxt;
  logic [GB-1:0]     cg_r, cg_nxt;
  evr_pkg::dir_t     dir_r, dir_nxt;

  logic [SB-1:0] magl_r, magl_nxt, magr_r, magr_nxt;
  logic          negl_r, negl_nxt, negr_r, negr_nxt;
  logic [GB-1:0] gain_r, gain_nxt, p_r, p_nxt, x_r, x_nxt, acc_r, acc_nxt, e_r, e_nxt;
  logic [2:0]    cnt_r, cnt_nxt;
  logic [SB-1:0] resl_r, resl_nxt, resr_r, resr_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [87:0]   odata_r, odata_nxt;

  logic                        div_start, div_done;
  logic [evr_pkg::DivBits-1:0] div_q;
  logic [SB-1:0]               mul_a;
  logic [GB-1:0]               mul_b;
  logic [evr_pkg::ProdBits-1:0] prod;

  evr_pkg::curve_t curve;
  logic            in_acc, cfg_hit, bypass, mono;
  logic [SB-1:0]   vl, vr;
  logic [GB-1:0]   p_clamp, acc_new, diff, blend;

  evr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .dividend({fd_r, GF'(0)}), .divisor(frames_r - 1'b1),
    .done(div_done), .quotient(div_q)
  );

  evr_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod(prod));

  function automatic logic [SB-1:0] saturate(input logic [SB:0] q, input logic neg,
                                             input logic wide);
    logic [SB:0] hi;
    logic [SB:0] res;
    hi = wide ? 33'h0_7FFF_FFFF : 33'h0_0000_7FFF;
    if (!neg) res = (q > hi) ? hi : q;
    else      res = (q > hi + 1'b1) ? -(hi + 1'b1) : -q;
    return res[SB-1:0];
  endfunction

  assign in_acc = in_tvalid && in_tready;
  assign curve  = evr_pkg::curve_decode(curve_r);
  assign mono   = (chan_r == 2'd1);
  assign bypass = (dir_r == evr_pkg::DIR_BYPASS) ||
                  (dir_r == evr_pkg::DIR_RISE && fd_r >= frames_r);
  assign vl = wide_r ? in_tdata[31:0] : {{16{in_tdata[15]}}, in_tdata[15:0]};
  assign vr = wide_r ? in_tdata[63:32] : {{16{in_tdata[47]}}, in_tdata[47:32]};
  assign p_clamp = (div_q > evr_pkg::DivBits'(evr_pkg::GainOne)) ? evr_pkg::GainOne
                                                                 : div_q[GB-1:0];
  assign acc_new = prod[GF+GB-1:GF];
  assign diff    = (target_r >= start_r) ? target_r - start_r : start_r - target_r;
  assign blend   = prod[GF+GB-1:GF];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      evr_pkg::S_IDLE:
        if (in_acc) begin
          if (bypass || frames_r == '0 || fd_r >= frames_r || frames_r == FB'(1))
            state_nxt = evr_pkg::S_SCL;
          else
            state_nxt = evr_pkg::S_DIV;
        end
      evr_pkg::S_DIV:
        if (div_done) state_nxt = curve.linear ? evr_pkg::S_BLD : evr_pkg::S_POW;
      evr_pkg::S_POW:  state_nxt = evr_pkg::S_POWW;
      evr_pkg::S_POWW: state_nxt = (cnt_r == 3'd1) ? evr_pkg::S_BLD : evr_pkg::S_POW;
      evr_pkg::S_BLD:  state_nxt = evr_pkg::S_BLDW;
      evr_pkg::S_BLDW: state_nxt = evr_pkg::S_SCL;
      evr_pkg::S_SCL:  state_nxt = evr_pkg::S_SCLW;
      evr_pkg::S_SCLW: state_nxt = evr_pkg::S_SCR;
      evr_pkg::S_SCR:  state_nxt = evr_pkg::S_SCRW;
      evr_pkg::S_SCRW: state_nxt = evr_pkg::S_OUT;
      evr_pkg::S_OUT:  if (!ovalid_r || out_tready) state_nxt = evr_pkg::S_IDLE;
      default:         state_nxt = evr_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    curve_nxt  = curve_r;
    start_nxt  = start_r;
    target_nxt = target_r;
    frames_nxt = frames_r;
    wide_nxt   = wide_r;
    chan_nxt   = chan_r;
    fd_nxt     = fd_r;
    cg_nxt     = cg_r;
    dir_nxt    = dir_r;
    magl_nxt   = magl_r;
    magr_nxt   = magr_r;
    negl_nxt   = negl_r;
    negr_nxt   = negr_r;
    gain_nxt   = gain_r;
    p_nxt      = p_r;
    x_nxt      = x_r;
    acc_nxt    = acc_r;
    e_nxt      = e_r;
    cnt_nxt    = cnt_r;
    resl_nxt   = resl_r;
    resr_nxt   = resr_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    div_start  = 1'b0;
    mul_a      = magl_r;
    mul_b      = gain_r;
    cfg_hit    = 1'b0;

    if (cfg_we) begin
      cfg_hit = 1'b1;
      case (cfg_addr)
        evr_pkg::REG_CURVE:  curve_nxt  = cfg_wdata[3:0];
        evr_pkg::REG_START:  start_nxt  = cfg_wdata[GB-1:0];
        evr_pkg::REG_TARGET: target_nxt = cfg_wdata[GB-1:0];
        evr_pkg::REG_FRAMES: frames_nxt = cfg_wdata[FB-1:0];
        evr_pkg::REG_WIDE:   wide_nxt   = cfg_wdata[0];
        evr_pkg::REG_CHAN:   chan_nxt   = cfg_wdata[1:0];
        default:             cfg_hit    = 1'b0;
      endcase
      if (cfg_hit) begin
        fd_nxt = '0;
        if (start_nxt < target_nxt)      dir_nxt = evr_pkg::DIR_RISE;
        else if (start_nxt > target_nxt) dir_nxt = evr_pkg::DIR_FALL;
        else                             dir_nxt = evr_pkg::DIR_BYPASS;
        cg_nxt = (frames_nxt == '0) ? target_nxt : start_nxt;
      end
    end

    case (state_r)
      evr_pkg::S_IDLE:
        if (in_acc) begin
          negl_nxt = vl[SB-1];
          negr_nxt = vr[SB-1];
          magl_nxt = vl[SB-1] ? ~vl + 1'b1 : vl;
          magr_nxt = vr[SB-1] ? ~vr + 1'b1 : vr;
          if (bypass) begin
            gain_nxt = evr_pkg::GainOne;
          end else if (frames_r == '0) begin
            cg_nxt   = target_r;
            gain_nxt = target_r;
          end else if (fd_r >= frames_r) begin
            gain_nxt = cg_r;
          end else if (frames_r == FB'(1)) begin
            cg_nxt   = target_r;
            gain_nxt = target_r;
            fd_nxt   = fd_r + 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      evr_pkg::S_DIV:
        if (div_done) begin
          p_nxt = p_clamp;
          e_nxt = p_clamp;
          case (curve.form)
            evr_pkg::FORM_IN:  x_nxt = p_clamp;
            evr_pkg::FORM_OUT: x_nxt = evr_pkg::GainOne - p_clamp;
            default:
              x_nxt = (p_clamp < evr_pkg::GainHalf) ? GB'({p_clamp, 1'b0})
                    : GB'({evr_pkg::GainOne - p_clamp, 1'b0});
          endcase
          acc_nxt = x_nxt;
          cnt_nxt = curve.power - 1'b1;
        end
      evr_pkg::S_POW: begin
        mul_a = SB'(acc_r);
        mul_b = x_r;
      end
      evr_pkg::S_POWW: begin
        acc_nxt = acc_new;
        cnt_nxt = cnt_r - 1'b1;
        case (curve.form)
          evr_pkg::FORM_IN:  e_nxt = acc_new;
          evr_pkg::FORM_OUT: e_nxt = evr_pkg::GainOne - acc_new;
          default:
            e_nxt = (p_r < evr_pkg::GainHalf) ? (acc_new >> 1)
                                              : evr_pkg::GainOne - (acc_new >> 1);
        endcase
      end
      evr_pkg::S_BLD: begin
        mul_a = SB'(diff);
        mul_b = e_r;
      end
      evr_pkg::S_BLDW: begin
        cg_nxt   = (target_r >= start_r) ? start_r + blend : start_r - blend;
        gain_nxt = cg_nxt;
        fd_nxt   = fd_r + 1'b1;
      end
      evr_pkg::S_SCL: begin
        mul_a = magl_r;
        mul_b = gain_r;
      end
      evr_pkg::S_SCLW: resl_nxt = saturate(prod[evr_pkg::ProdBits-1:GF], negl_r, wide_r);
      evr_pkg::S_SCR: begin
        mul_a = magr_r;
        mul_b = gain_r;
      end
      evr_pkg::S_SCRW:
        resr_nxt = mono ? '0 : saturate(prod[evr_pkg::ProdBits-1:GF], negr_r, wide_r);
      evr_pkg::S_OUT:
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {7'd0, gain_r, resr_r, resl_r};
        end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= evr_pkg::S_IDLE;
      curve_r  <= '0;
      start_r  <= evr_pkg::GainOne;
      target_r <= evr_pkg::GainOne;
      frames_r <= '0;
      wide_r   <= 1'b1;
      chan_r   <= 2'd2;
      fd_r     <= '0;
      cg_r     <= evr_pkg::GainOne;
      dir_r    <= evr_pkg::DIR_BYPASS;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      curve_r  <= curve_nxt;
      start_r  <= start_nxt;
      target_r <= target_nxt;
      frames_r <= frames_nxt;
      wide_r   <= wide_nxt;
      chan_r   <= chan_nxt;
      fd_r     <= fd_nxt;
      cg_r     <= cg_nxt;
      dir_r    <= dir_nxt;
      ovalid_r <= ovalid_nxt;
    end
    magl_r  <= magl_nxt;
    magr_r  <= magr_nxt;
    negl_r  <= negl_nxt;
    negr_r  <= negr_nxt;
    gain_r  <= gain_nxt;
    p_r     <= p_nxt;
    x_r     <= x_nxt;
    acc_r   <= acc_nxt;
    e_r     <= e_nxt;
    cnt_r   <= cnt_nxt;
    resl_r  <= resl_nxt;
    resr_r  <= resr_nxt;
    odata_r <= odata_nxt;
  end

  assign in_tready  = (state_r == evr_pkg::S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

@@ sv/evr_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on evr_pkg.
module evr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [evr_pkg::DivBits-1:0]   dividend,
  input  logic [evr_pkg::FrameBits-1:0] divisor,
  output logic                          done,
  output logic [evr_pkg::DivBits-1:0]   quotient
);

  logic [evr_pkg::DivCntW-1:0]   cnt_r, cnt_nxt;
  logic [evr_pkg::DivBits-1:0]   quo_r, quo_nxt;
  logic [evr_pkg::FrameBits-1:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic                          done_r, done_nxt;
  logic [evr_pkg::FrameBits:0]   shifted;
  logic                          fits;

  always_comb begin
    shifted  = {rem_r, quo_r[evr_pkg::DivBits-1]};
    fits     = shifted >= {1'b0, dvs_r};
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = evr_pkg::DivCntW'(evr_pkg::DivBits);
      quo_nxt = dividend;
      rem_nxt = '0;
      dvs_nxt = divisor;
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? evr_pkg::FrameBits'(shifted - {1'b0, dvs_r})
                      : shifted[evr_pkg::FrameBits-1:0];
      quo_nxt  = {quo_r[evr_pkg::DivBits-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == evr_pkg::DivCntW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ sv/evr_mul.sv @@
// Shared 32 x 17 unsigned multiplier with registered product.
// Depends on evr_pkg.
module evr_mul (
  input  logic                          clk,
  input  logic [evr_pkg::SampBits-1:0]  op_a,
  input  logic [evr_pkg::GainBits-1:0]  op_b,
  output logic [evr_pkg::ProdBits-1:0]  prod
);

  logic [evr_pkg::ProdBits-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= evr_pkg::ProdBits'(op_a) * evr_pkg::ProdBits'(op_b);
  end

  assign prod = prod_r;

endmodule

@@ sv/evr_chk.sv @@
// Port-level checker for the eased volume ramp, bound to the top level.
// Depends on eased_volume_ramp's ports only.
module evr_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [87:0] out_tdata
);

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("accepted a transaction back to back");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output transaction changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[87:81] == 7'd0 && out_tdata[80:64] <= 17'h1FFFF)
    else $error("padding bits set");

endmodule

bind eased_volume_ramp evr_chk u_evr_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);

@@ dv/eased_volume_ramp_tb.sv @@
// Self-checking bench for eased_volume_ramp: streams stereo frames through the block
// and checks each scaled frame against a built-in gain-ramp predictor.
// Depends on evr_pkg and the eased_volume_ramp RTL.
`timescale 1ns / 1ps
module eased_volume_ramp_tb;

  typedef struct packed {
    logic [31:0] left;
    logic [31:0] right;
    logic [16:0] gain;
  } scaled_frame_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [63:0]                  in_tdata = '0;  // sample_left, sample_right
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [87:0]                  out_tdata;      // scaled_left, scaled_right, gain_used
  logic                         cfg_we = 1'b0;
  logic [evr_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [evr_pkg::CfgDataW-1:0] cfg_wdata = '0;

  eased_volume_ramp uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // Ramp predictor state and configuration copy
  logic [3:0]    m_curve;
  logic [63:0]   m_start, m_target, m_frames, m_wide, m_chan;
  logic [63:0]   m_done, m_gain;
  evr_pkg::dir_t m_dir;

  logic [63:0]   send_q[$];
  scaled_frame_t exp_frames[$];
  int            err_count = 0;
  bit            idle_en = 1'b1;
  bit            hold_req = 1'b0;
  bit            hold_taken = 1'b0;
  int            hold_cnt = 0;
  int            in_gap = 0;
  int            out_stall = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  function automatic logic [63:0] fx_power(input logic [63:0] x, input int n);
    logic [63:0] acc;
    acc = x;
    for (int k = 1; k < n; k++) acc = (acc * x) >> evr_pkg::GainFrac;
    return acc;
  endfunction

  function automatic logic [63:0] eased(input logic [63:0] p);
    int n, form;
    logic [63:0] one;
    one = 64'd1 << evr_pkg::GainFrac;
    if (m_curve == 4'd0 || m_curve > 4'd12) return p;
    n = 2 + (m_curve - 1) / 3;
    form = (m_curve - 1) % 3;
    if (form == 0) return fx_power(p, n);
    if (form == 1) return one - fx_power(one - p, n);
    if (p < one / 2) return fx_power(2 * p, n) >> 1;
    return one - (fx_power(2 * (one - p), n) >> 1);
  endfunction

  function automatic longint widen(input logic [31:0] raw);
    if (m_wide[0]) return longint'(signed'(raw));
    return longint'(signed'(raw[15:0]));
  endfunction

  function automatic logic [31:0] scale(input longint s, input logic [63:0] g);
    longint r, hi;
    logic [63:0] mag;
    mag = (s < 0) ? -s : s;
    r = longint'((mag * g) >> evr_pkg::GainFrac);
    if (s < 0) r = -r;
    hi = m_wide[0] ? 64'sh7FFFFFFF : 64'sh7FFF;
    if (r > hi) r = hi;
    if (r < -hi - 1) r = -hi - 1;
    return r[31:0];
  endfunction

  // Predict one frame and queue it for sending
  task automatic send_frame(input logic [31:0] l, input logic [31:0] r);
    scaled_frame_t f;
    logic [63:0] g, p;
    if (m_dir == evr_pkg::DIR_BYPASS ||
        (m_dir == evr_pkg::DIR_RISE && m_done >= m_frames)) begin
      g = 64'd1 << evr_pkg::GainFrac;
    end else begin
      if (m_frames == 0) begin
        m_gain = m_target;
      end else if (m_done < m_frames) begin
        if (m_frames == 1) begin
          m_gain = m_target;
        end else begin
          p = (m_done << evr_pkg::GainFrac) / (m_frames - 1);
          if (p > (64'd1 << evr_pkg::GainFrac)) p = 64'd1 << evr_pkg::GainFrac;
          p = eased(p);
          if (m_target >= m_start)
            m_gain = m_start + (((m_target - m_start) * p) >> evr_pkg::GainFrac);
          else
            m_gain = m_start - (((m_start - m_target) * p) >> evr_pkg::GainFrac);
          m_gain &= 64'h1FFFF;
        end
        m_done = (m_done + 1) & 64'hFFFFFF;
      end
      g = m_gain;
    end
    f.left = scale(widen(l), g);
    f.right = (m_chan == 1) ? 32'd0 : scale(widen(r), g);
    f.gain = g[16:0];
    exp_frames.push_back(f);
    send_q.push_back({r, l});
  endtask

  task automatic write_reg(input evr_pkg::reg_idx_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[evr_pkg::CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      evr_pkg::REG_CURVE:  m_curve = val[3:0];
      evr_pkg::REG_START:  m_start = val & 64'h1FFFF;
      evr_pkg::REG_TARGET: m_target = val & 64'h1FFFF;
      evr_pkg::REG_FRAMES: m_frames = val & 64'hFFFFFF;
      evr_pkg::REG_WIDE:   m_wide = val & 64'd1;
      default:             m_chan = val & 64'd3;
    endcase
    m_done = 0;
    if (m_start < m_target) m_dir = evr_pkg::DIR_RISE;
    else if (m_start > m_target) m_dir = evr_pkg::DIR_FALL;
    else m_dir = evr_pkg::DIR_BYPASS;
    m_gain = (m_frames == 0) ? m_target : m_start;
  endtask

  // Block must be fully drained (and past its latency) before a register write
  task automatic drain;
    while (send_q.size() != 0 || exp_frames.size() != 0 || in_tvalid) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic random_config;
    logic [63:0] fr;
    case ($urandom_range(0, 9))
      0: fr = 64'd0;
      1: fr = 64'd1;
      2: fr = 64'hFFFFFF;
      3: fr = 64'($urandom_range(100, 5000));
      default: fr = 64'($urandom_range(2, 40));
    endcase
    write_reg(evr_pkg::REG_CURVE, 64'($urandom_range(0, 15)));
    write_reg(evr_pkg::REG_START,
              ($urandom_range(0, 5) == 0) ? 64'd131071 : 64'($urandom_range(0, 131071)));
    write_reg(evr_pkg::REG_TARGET,
              ($urandom_range(0, 5) == 0) ? 64'd0 : 64'($urandom_range(0, 131071)));
    write_reg(evr_pkg::REG_FRAMES, fr);
    write_reg(evr_pkg::REG_WIDE, 64'($urandom_range(0, 1)));
    write_reg(evr_pkg::REG_CHAN, ($urandom_range(0, 7) == 0) ? 64'($urandom_range(0, 3))
                                                             : 64'($urandom_range(1, 2)));
  endtask

  // Driver
  always @(posedge clk) begin
    int g;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        g = idle_en ? $urandom_range(0, 16) : 0;
        if (g == 0 && send_q.size() != 0) begin
          in_tdata <= send_q.pop_front();
        end else begin
          in_tvalid <= 1'b0;
          in_gap <= g;
        end
      end else if (!in_tvalid) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
        end else if (send_q.size() != 0) begin
          in_tdata <= send_q.pop_front();
          in_tvalid <= 1'b1;
        end
      end
    end
  end

  // Monitor and result check
  always @(posedge clk) begin
    scaled_frame_t want;
    int st;
    bit rdy;
    int hc;
    if (rst_n) begin
      st = out_stall;
      hc = hold_cnt;
      if (out_tvalid && out_tready) begin
        if (exp_frames.size() == 0) begin
          report_mismatch("unexpected frame", out_tdata[63:0], 64'd0);
        end else begin
          want = exp_frames.pop_front();
          if (out_tdata[31:0] !== want.left)
            report_mismatch("scaled_left", out_tdata[31:0], want.left);
          if (out_tdata[63:32] !== want.right)
            report_mismatch("scaled_right", out_tdata[63:32], want.right);
          if (out_tdata[80:64] !== want.gain)
            report_mismatch("gain_used", out_tdata[80:64], want.gain);
        end
        st = idle_en ? $urandom_range(0, 16) : 0;
      end
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hc = 400;
      end
      if (hc > 0) begin
        hc--;
        rdy = 1'b0;
      end else if (st > 0) begin
        st--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      hold_cnt <= hc;
      out_stall <= st;
      out_tready <= rdy;
    end
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int n;
    n = 0;
    m_curve = 0; m_start = 65536; m_target = 65536; m_frames = 0;
    m_wide = 1; m_chan = 2; m_done = 0; m_gain = 65536; m_dir = evr_pkg::DIR_BYPASS;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Reset state: bypass, extremes of the samples
    send_frame(32'h7FFFFFFF, 32'h80000000);
    send_frame(32'h00000000, 32'hFFFFFFFF);
    drain();
    // One-frame fall to silence, then a finished fall keeps its gain
    write_reg(evr_pkg::REG_START, 64'd131071);
    write_reg(evr_pkg::REG_TARGET, 64'd0);
    write_reg(evr_pkg::REG_FRAMES, 64'd1);
    send_frame(32'h7FFFFFFF, 32'h80000000);
    send_frame(32'h12345678, 32'h80000000);
    drain();
    // Equal start and target bypass at unity gain in 16-bit mono
    write_reg(evr_pkg::REG_TARGET, 64'd131071);
    write_reg(evr_pkg::REG_WIDE, 64'd0);
    write_reg(evr_pkg::REG_CHAN, 64'd1);
    send_frame(32'h00007FFF, 32'h00008000);
    send_frame(32'hABCD8000, 32'h7FFF7FFF);
    drain();
    // Zero-length rise bypasses; zero-length fall takes the target
    write_reg(evr_pkg::REG_START, 64'd0);
    write_reg(evr_pkg::REG_FRAMES, 64'd0);
    send_frame(32'h00001234, 32'h0000FFFF);
    drain();
    write_reg(evr_pkg::REG_START, 64'd131071);
    write_reg(evr_pkg::REG_TARGET, 64'd100);
    send_frame(32'h00007FFF, 32'h00008000);
    drain();
    // Each curve over a short rise past its end
    write_reg(evr_pkg::REG_WIDE, 64'd1);
    write_reg(evr_pkg::REG_CHAN, 64'd2);
    write_reg(evr_pkg::REG_START, 64'd1000);
    write_reg(evr_pkg::REG_TARGET, 64'd120000);
    for (int c = 0; c < 16; c++) begin
      write_reg(evr_pkg::REG_CURVE, 64'(c));
      write_reg(evr_pkg::REG_FRAMES, 64'd3);
      for (int i = 0; i < 4; i++) send_frame($urandom, $urandom);
      drain();
    end
    // Random phases
    while (n < 1050) begin
      random_config();
      idle_en = ($urandom_range(0, 3) != 0);
      for (int i = $urandom_range(10, 60); i > 0; i--) begin
        send_frame($urandom, $urandom);
        n++;
      end
      if (n > 300 && !hold_req) begin
        @(posedge clk);
        hold_req <= 1'b1;
      end
      drain();
    end
    for (int i = 0; i < 200; i++) @(posedge clk);
    if (exp_frames.size() != 0)
      report_mismatch("frames left over", 64'(exp_frames.size()), 64'd0);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ eased_volume_ramp.f @@
sv/evr_pkg.sv
sv/evr_div.sv
sv/evr_mul.sv
sv/eased_volume_ramp.sv
sv/evr_chk.sv
dv/eased_volume_ramp_tb.sv
